### design/agm_pkg.sv
`default_nettype none

package agm_pkg;

  localparam int unsigned LANE_MAX = 8;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PAIR_W   = SAMPLE_W + 2;
  localparam int unsigned SUM_W    = SAMPLE_W + 3;
  localparam int unsigned MAG_W    = SUM_W;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned SHIFT_W  = 4;
  localparam int unsigned GAIN_OUT_W = 17;

  localparam logic [LIMIT_W-1:0] POS_LIMIT = 16'd32767;
  localparam logic [LIMIT_W-1:0] NEG_LIMIT = 16'd32768;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd5;

  localparam logic [SAMPLE_W-1:0] OUT_POS_CLAMP = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] OUT_NEG_CLAMP = 16'h8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MAG,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_OUT
  } agm_state_t;

endpackage

`default_nettype wire

### design/agm_lane.sv
`default_nettype none

// One mixing lane: sign-extends its sample and gates it with the lane's present bit.
module agm_lane
  import agm_pkg::*;
(
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       present,
  output logic signed [SUM_W-1:0]         term
);

  assign term = present ? SUM_W'(sample) : '0;

endmodule

`default_nettype wire

### design/agm_merge.sv
`default_nettype none

// Two-level registered adder tree that combines the lane terms into one sum.
module agm_merge
  import agm_pkg::*;
(
  input  wire logic                               clk,
  input  wire logic                               load,
  input  wire logic [LANE_MAX-1:0][SUM_W-1:0]     terms,
  output logic signed [SUM_W-1:0]                 sum_r
);

  localparam int unsigned PAIRS = LANE_MAX / 2;

  logic signed [PAIR_W-1:0] pair_r   [PAIRS];
  logic signed [PAIR_W-1:0] pair_nxt [PAIRS];
  logic signed [SUM_W-1:0]  sum_nxt;

  always_comb begin
    for (int p = 0; p < PAIRS; p++) begin
      pair_nxt[p] = PAIR_W'($signed(terms[2*p])) + PAIR_W'($signed(terms[2*p+1]));
    end
    sum_nxt = '0;
    for (int p = 0; p < PAIRS; p++) begin
      sum_nxt = sum_nxt + SUM_W'(pair_r[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int p = 0; p < PAIRS; p++) begin
        pair_r[p] <= pair_nxt[p];
      end
    end
    sum_r <= sum_nxt;
  end

endmodule

`default_nettype wire

### design/agm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The limit is below the divisor,
// so the quotient of (limit << QW) / divisor fits in QW bits.
module agm_div
  import agm_pkg::*;
#(
  parameter int unsigned QW = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [LIMIT_W-1:0] limit,
  input  wire logic [MAG_W-1:0]   divisor,
  output logic                    done_r,
  output logic [QW-1:0]           quot_r
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic             busy_r, busy_nxt;
  logic             done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [MAG_W-1:0] rem_r, rem_nxt;
  logic [MAG_W-1:0] d_r, d_nxt;
  logic [QW-1:0]    quot_nxt;
  logic [MAG_W:0]   rem2;
  logic [MAG_W:0]   diff;
  logic             ge;

  always_comb begin
    rem2     = {rem_r, 1'b0};
    diff     = rem2 - {1'b0, d_r};
    ge       = rem2 >= {1'b0, d_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(QW);
      rem_nxt  = MAG_W'(limit);
      d_nxt    = divisor;
      quot_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[MAG_W-1:0] : rem2[MAG_W-1:0];
      quot_nxt = {quot_r[QW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    d_r    <= d_nxt;
    quot_r <= quot_nxt;
  end

endmodule

`default_nettype wire

### design/adaptive_gain_audio_mixer.sv
`default_nettype none

// A word passes through the states SUM, MAG, MUL and CHK, then DIV when the mix clips
// (the serial divider adds one bit a cycle), and then OUT, which holds the result
// until the output register is free. in_ready is high only between words, in IDLE,
// so a new word is accepted only once the last result has been written.
// Reset (rst_n low, synchronous) sets the gain to unity, recovery_shift to 5 and
// empties the result register.
module adaptive_gain_audio_mixer
  import agm_pkg::*;
#(
  parameter int unsigned LANES          = 8,
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_lane0_sample,
  input  wire logic signed [SAMPLE_W-1:0] in_lane1_sample,
  input  wire logic signed [SAMPLE_W-1:0] in_lane2_sample,
  input  wire logic signed [SAMPLE_W-1:0] in_lane3_sample,
  input  wire logic signed [SAMPLE_W-1:0] in_lane4_sample,
  input  wire logic signed [SAMPLE_W-1:0] in_lane5_sample,
  input  wire logic signed [SAMPLE_W-1:0] in_lane6_sample,
  input  wire logic signed [SAMPLE_W-1:0] in_lane7_sample,
  input  wire logic [LANE_MAX-1:0]        in_lane_present,
  input  wire logic                       in_run_start,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      out_mixed_sample,
  output logic                            out_clipped,
  output logic [GAIN_OUT_W-1:0]           out_gain_now,
  input  wire logic                       cfg_wr_en,
  input  wire logic [SHIFT_W-1:0]         cfg_wr_data
);

  // Gain is unsigned fixed point with GAIN_FRAC_BITS fraction bits plus one
  // integer bit, so unity is exactly representable.
  localparam int unsigned GW     = GAIN_FRAC_BITS + 1;
  localparam int unsigned PROD_W = MAG_W + GW;
  localparam logic [GW-1:0] UNITY = GW'(1) << GAIN_FRAC_BITS;

  logic [LANE_MAX-1:0][SAMPLE_W-1:0] samples;
  logic [LANE_MAX-1:0][SUM_W-1:0]    terms;
  logic signed [SUM_W-1:0]           sum_r;

  agm_state_t state_r, state_nxt;

  logic [GW-1:0]         gain_r, gain_nxt;
  logic [SHIFT_W-1:0]    shift_r, shift_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]   mixed_r, mixed_nxt;
  logic                  clipped_r, clipped_nxt;
  logic [GAIN_OUT_W-1:0] gain_out_r, gain_out_nxt;

  logic                  neg_r, neg_nxt;
  logic [MAG_W-1:0]      mag_r, mag_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [MAG_W-1:0]      smag_r, smag_nxt;
  logic                  clip_r, clip_nxt;

  logic                  accept;
  logic                  merge_load;
  logic [MAG_W-1:0]      smag_c;
  logic                  clip_c;
  logic [LIMIT_W-1:0]    limit_c;
  logic                  div_start;
  logic                  div_done;
  logic [GAIN_FRAC_BITS-1:0] div_quot;
  logic [GW-1:0]         gain_base;
  logic [GW-1:0]         gain_rec;
  logic [GW-1:0]         gain_gap;
  logic [GW+GAIN_OUT_W-1:0] gain_ext;
  logic                  out_free;

  assign samples = {in_lane7_sample, in_lane6_sample, in_lane5_sample, in_lane4_sample,
                    in_lane3_sample, in_lane2_sample, in_lane1_sample, in_lane0_sample};

  // One lane per configured source; the lanes past LANES contribute nothing.
  for (genvar k = 0; k < LANE_MAX; k++) begin : g_lane
    if (k < LANES) begin : g_on
      agm_lane u_lane (
        .sample  (samples[k]),
        .present (in_lane_present[k]),
        .term    (terms[k])
      );
    end else begin : g_off
      assign terms[k] = '0;
    end
  end

  assign accept     = in_valid && in_ready;
  assign merge_load = accept;

  agm_merge u_merge (
    .clk   (clk),
    .load  (merge_load),
    .terms (terms),
    .sum_r (sum_r)
  );

  // The scaled magnitude after truncation never exceeds the unscaled magnitude,
  // so MAG_W bits above the fraction are enough.
  assign smag_c  = prod_r[GAIN_FRAC_BITS +: MAG_W];
  assign clip_c  = neg_r ? (smag_c > MAG_W'(NEG_LIMIT)) : (smag_c > MAG_W'(POS_LIMIT));
  assign limit_c = neg_r ? NEG_LIMIT : POS_LIMIT;
  assign div_start = (state_r == ST_CHK) && clip_c;

  agm_div #(
    .QW (GAIN_FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .limit   (limit_c),
    .divisor (smag_c),
    .done_r  (div_done),
    .quot_r  (div_quot)
  );

  // A clip replaces the gain by the quotient; then the gain creeps back toward
  // unity by a shifted fraction of the remaining gap.
  assign gain_base = clip_r ? {1'b0, div_quot} : gain_r;
  assign gain_gap  = UNITY - gain_base;
  assign gain_rec  = (gain_base < UNITY) ? (gain_base + (gain_gap >> shift_r)) : gain_base;
  assign gain_ext  = {{GAIN_OUT_W{1'b0}}, gain_rec};
  assign out_free  = !out_valid_r || out_ready;

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_mixed_sample = mixed_r;
  assign out_clipped      = clipped_r;
  assign out_gain_now     = gain_out_r;

  always_comb begin
    state_nxt     = state_r;
    gain_nxt      = gain_r;
    shift_nxt     = shift_r;
    out_valid_nxt = out_valid_r;
    mixed_nxt     = mixed_r;
    clipped_nxt   = clipped_r;
    gain_out_nxt  = gain_out_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    prod_nxt      = prod_r;
    smag_nxt      = smag_r;
    clip_nxt      = clip_r;

    if (cfg_wr_en) begin
      shift_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // A run start puts the gain back at unity before this word is scaled.
          if (in_run_start) begin
            gain_nxt = UNITY;
          end
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        // Scaling the magnitude makes the truncating shift round toward zero.
        neg_nxt   = sum_r[SUM_W-1];
        mag_nxt   = sum_r[SUM_W-1] ? MAG_W'(-sum_r) : MAG_W'(sum_r);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(mag_r) * PROD_W'(gain_r);
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        smag_nxt  = smag_c;
        clip_nxt  = clip_c;
        state_nxt = clip_c ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          clipped_nxt   = clip_r;
          if (clip_r) begin
            mixed_nxt = neg_r ? OUT_NEG_CLAMP : OUT_POS_CLAMP;
          end else begin
            mixed_nxt = neg_r ? (-smag_r[SAMPLE_W-1:0]) : smag_r[SAMPLE_W-1:0];
          end
          gain_nxt     = gain_rec;
          gain_out_nxt = gain_ext[GAIN_OUT_W-1:0];
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= UNITY;
      shift_r     <= SHIFT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      gain_r      <= gain_nxt;
      shift_r     <= shift_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mixed_r    <= mixed_nxt;
    clipped_r  <= clipped_nxt;
    gain_out_r <= gain_out_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    prod_r     <= prod_nxt;
    smag_r     <= smag_nxt;
    clip_r     <= clip_nxt;
  end

endmodule

`default_nettype wire
